// File: sv/rsaf_pkg.sv
// ----------------------------------------------------------------------------
// rsaf_pkg
// Shared widths, register indexes and helper types for the range filter.
// ----------------------------------------------------------------------------
package rsaf_pkg;

    localparam int DIST_W    = 16;
    localparam int OFS_W     = 11;
    localparam int LIM_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = OFS_W;
    localparam int CAL_W     = DIST_W + 2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(10);
    localparam logic [LIM_W-1:0] RUN_MAX     = {LIM_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET = 1'b0,
        CFG_LIMIT  = 1'b1
    } cfg_index_t;

    typedef logic [DIST_W-1:0] dist_t;

endpackage

// File: sv/range_sample_average_filter_unit.sv
// ----------------------------------------------------------------------------
// range_sample_average_filter_unit
// Calibrates range readings and averages valid ones over a ring of WINDOW.
// ----------------------------------------------------------------------------
//  channel  | signals                                              | dir
//  ---------+------------------------------------------------------+-----
//  cfg      | cfg_wr_en, cfg_index, cfg_data                       | in
//  in       | in_valid/in_ready: action, raw_distance, range_status| in
//  out      | out_valid/out_ready: filtered_distance,              | out
//           |   last_distance, reading_valid, restart_request      |
//
//  Valid reading: S_READ, then the bit-serial divider, one sum bit per
//  cycle, then S_DONE. Invalid or clear beat: straight from S_IDLE to S_DONE.
//  One beat in flight; the output register holds a result until taken,
//  and a new beat is accepted while it waits.
//  Reset is asynchronous; the ring needs no clear, entries are read only
//  after they are written.
// ----------------------------------------------------------------------------
module range_sample_average_filter_unit #(
    parameter int WINDOW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rsaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsaf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [rsaf_pkg::DIST_W-1:0]    raw_distance,
    input  logic [7:0]                     range_status,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rsaf_pkg::DIST_W-1:0]    filtered_distance,
    output logic [rsaf_pkg::DIST_W-1:0]    last_distance,
    output logic                           reading_valid,
    output logic                           restart_request
);
    import rsaf_pkg::*;

    localparam int SUM_W  = DIST_W + $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [LIM_W-1:0]  limit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    dist_t             avg_reg;
    dist_t             latest_reg;
    logic [LIM_W-1:0]  run_reg;
    dist_t             cal_reg;
    logic              res_valid_reg;
    logic              res_restart_reg;
    logic              out_valid_reg;
    dist_t             out_filt_reg;
    dist_t             out_last_reg;
    logic              out_rv_reg;
    logic              out_rr_reg;

    logic              accept;
    logic [CAL_W-1:0]  cal_sum;
    dist_t             cal_next;
    logic [LIM_W-1:0]  run_next;
    logic              full;
    logic [SUM_W-1:0]  old_ext;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_next;
    logic [SLOT_W-1:0] slot_next;
    dist_t             ring_rd;
    logic              div_start;
    logic              div_done;
    dist_t             div_q;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cal_sum = {2'b00, raw_distance} + {{(CAL_W-OFS_W){offset_reg[OFS_W-1]}}, offset_reg};
        if (cal_sum[CAL_W-1])
        begin
            cal_next = '0;
        end
        else if (cal_sum[CAL_W-2])
        begin
            cal_next = {DIST_W{1'b1}};
        end
        else
        begin
            cal_next = cal_sum[DIST_W-1:0];
        end
        run_next   = (run_reg == RUN_MAX) ? run_reg : run_reg + LIM_W'(1);
        full       = (count_reg == CNT_W'(WINDOW));
        old_ext    = full ? SUM_W'(ring_rd) : '0;
        sum_next   = sum_reg + SUM_W'(cal_reg) - old_ext;
        count_next = full ? count_reg : count_reg + CNT_W'(1);
        slot_next  = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
        div_start  = (state_reg == S_READ);
    end

    rsaf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (div_start),
        .wr_addr (slot_reg),
        .wr_data (cal_reg),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (ring_rd)
    );

    rsaf_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            offset_reg      <= '0;
            limit_reg       <= LIMIT_RESET;
            slot_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            avg_reg         <= '0;
            latest_reg      <= '0;
            run_reg         <= '0;
            res_valid_reg   <= 1'b0;
            res_restart_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_OFFSET: offset_reg <= cfg_data;
                    CFG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                    default:    ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (action || (range_status != 8'd0 && run_next >= limit_reg))
                        begin
                            slot_reg        <= '0;
                            count_reg       <= '0;
                            sum_reg         <= '0;
                            avg_reg         <= '0;
                            latest_reg      <= '0;
                            run_reg         <= '0;
                            res_valid_reg   <= 1'b0;
                            res_restart_reg <= !action;
                            state_reg       <= S_DONE;
                        end
                        else if (range_status != 8'd0)
                        begin
                            latest_reg      <= '0;
                            run_reg         <= run_next;
                            res_valid_reg   <= 1'b0;
                            res_restart_reg <= 1'b0;
                            state_reg       <= S_DONE;
                        end
                        else
                        begin
                            cal_reg         <= cal_next;
                            latest_reg      <= cal_next;
                            run_reg         <= '0;
                            res_valid_reg   <= 1'b1;
                            res_restart_reg <= 1'b0;
                            state_reg       <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    slot_reg  <= slot_next;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_q;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_filt_reg  <= avg_reg;
                        out_last_reg  <= latest_reg;
                        out_rv_reg    <= res_valid_reg;
                        out_rr_reg    <= res_restart_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid         = out_valid_reg;
    assign filtered_distance = out_filt_reg;
    assign last_distance     = out_last_reg;
    assign reading_valid     = out_rv_reg;
    assign restart_request   = out_rr_reg;

endmodule

// File: sv/rsaf_ram.sv
// ----------------------------------------------------------------------------
// rsaf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/rsaf_div.sv
// ----------------------------------------------------------------------------
// rsaf_div
// Bit-serial restoring divider: one dividend bit per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module rsaf_div #(
    parameter int SUM_W = 19,
    parameter int CNT_W = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SUM_W-1:0]           dividend,
    input  logic [CNT_W-1:0]           divisor,
    output logic                       done,
    output logic [rsaf_pkg::DIST_W-1:0] quotient
);
    import rsaf_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  shift_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [CNT_W:0]    rem_sh;
    logic              q_bit;
    logic [CNT_W:0]    rem_diff;
    logic [CNT_W-1:0]  rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, shift_reg[SUM_W-1]};
        q_bit    = (rem_sh >= {1'b0, dvs_reg});
        rem_diff = rem_sh - {1'b0, dvs_reg};
        rem_next = q_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dvs_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[SUM_W-2:0], q_bit};
            rem_reg   <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg[DIST_W-1:0];

endmodule

// File: tb/tb_range_sample_average_filter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_sample_average_filter_unit
// Self-checking bench for the range averaging filter. A queue-fed driver
// offers readings with random gaps, the sink stalls at random, and every
// accepted beat is run through an in-bench model of the calibration, invalid
// counter and moving-average ring. Results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_range_sample_average_filter_unit;

    import rsaf_pkg::*;

    localparam int WINDOW       = 8;
    localparam int HALF_PERIOD  = 2;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic        act;
        dist_t       raw;
        logic [7:0]  status;
    } reading_t;

    typedef struct {
        dist_t filt;
        dist_t last;
        logic  ok;
        logic  restart;
    } avg_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    cfg_index_t       cfg_index = CFG_OFFSET;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             action = 1'b0;
    dist_t            raw_distance = '0;
    logic [7:0]       range_status = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    dist_t            filtered_distance;
    dist_t            last_distance;
    logic             reading_valid;
    logic             restart_request;

    // filter model state
    dist_t                   avg_ring [WINDOW];
    int                      ring_slot = 0;
    int                      ring_fill = 0;
    int                      ring_sum = 0;
    dist_t                   avg_held = '0;
    dist_t                   last_cal = '0;
    logic [LIM_W-1:0]        bad_run = '0;
    logic signed [OFS_W-1:0] cal_offset = '0;
    logic [LIM_W-1:0]        bad_limit = LIMIT_RESET;

    reading_t    pending_q [$];
    avg_result_t expected_q [$];
    reading_t    sender_item;
    int          drv_cnt = 0;
    int          acc_cnt = 0;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_left = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    bit          src_idle_en = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          err_cnt = 0;
    int          quiet = 0;

    range_sample_average_filter_unit #(
        .WINDOW(WINDOW)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .raw_distance     (raw_distance),
        .range_status     (range_status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .filtered_distance(filtered_distance),
        .last_distance    (last_distance),
        .reading_valid    (reading_valid),
        .restart_request  (restart_request)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic avg_result_t filter_step(input reading_t rd);
        avg_result_t res;
        int          cal;
        logic        wipe;
        res.ok = 1'b0;
        res.restart = 1'b0;
        wipe = 1'b0;
        if (rd.act) begin
            wipe = 1'b1;
        end
        else if (rd.status != 8'd0) begin
            last_cal = '0;
            if (bad_run != RUN_MAX)
                bad_run = bad_run + 1'b1;
            if (bad_run >= bad_limit)
            begin
                wipe = 1'b1;
                res.restart = 1'b1;
            end
        end
        else begin
            cal = int'(rd.raw) + int'(cal_offset);
            if (cal < 0)
                cal = 0;
            else if (cal > 65535)
                cal = 65535;
            res.ok = 1'b1;
            bad_run = '0;
            last_cal = dist_t'(cal);
            if (ring_fill < WINDOW)
                ring_fill++;
            else
                ring_sum -= int'(avg_ring[ring_slot]);
            avg_ring[ring_slot] = dist_t'(cal);
            ring_sum += cal;
            ring_slot = (ring_slot + 1) % WINDOW;
            avg_held = dist_t'(ring_sum / ring_fill);
        end
        if (wipe)
        begin
            ring_slot = 0;
            ring_fill = 0;
            ring_sum = 0;
            avg_held = '0;
            last_cal = '0;
            bad_run = '0;
        end
        res.filt = avg_held;
        res.last = last_cal;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(40, 120);
    endfunction

    function automatic dist_t rand_raw();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return dist_t'($urandom);
        else if (r < 70)
            return dist_t'($urandom_range(0, 2000));
        else if (r < 85)
            return dist_t'($urandom_range(64500, 65535));
        else
            return dist_t'($urandom_range(0, 1100));
    endfunction

    function automatic void queue_item(input logic act, input dist_t raw, input logic [7:0] st);
        reading_t rd;
        rd.act = act;
        rd.raw = raw;
        rd.status = st;
        pending_q.push_back(rd);
    endfunction

    task automatic queue_random(input int count);
        int k;
        int r;
        int run;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                queue_item(1'b0, rand_raw(), 8'd0);
            else if (r < 86)
                queue_item(1'b0, rand_raw(), 8'($urandom_range(1, 255)));
            else if (r < 92)
            begin
                run = int'(bad_limit) + $urandom_range(0, 2) - 1;
                if (run < 1)
                    run = 1;
                if (run > 20)
                    run = 20;
                repeat (run) queue_item(1'b0, rand_raw(), 8'($urandom_range(1, 255)));
            end
            else if (r < 96)
                queue_item(1'b1, dist_t'($urandom), 8'($urandom));
            else
                queue_item(1'b0, dist_t'($urandom), 8'($urandom));
        end
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_OFFSET: cal_offset = value[OFS_W-1:0];
            CFG_LIMIT:  bad_limit = value[LIM_W-1:0];
            default:    ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_mode(input int ofs, input int lim);
        write_cfg(CFG_OFFSET, CFG_W'(ofs));
        write_cfg(CFG_LIMIT, CFG_W'(lim));
        @(posedge clk);
    endtask

    task automatic settle();
        @(negedge clk);
        while (pending_q.size() != 0 || drv_cnt != acc_cnt || expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && drv_cnt == acc_cnt)
        begin
            if (src_gap > 0)
            begin
                in_valid <= 1'b0;
                src_gap  <= src_gap - 1;
            end
            else if (pending_q.size() != 0)
            begin
                sender_item = pending_q.pop_front();
                in_valid     <= 1'b1;
                action       <= sender_item.act;
                raw_distance <= sender_item.raw;
                range_status <= sender_item.status;
                drv_cnt      <= drv_cnt + 1;
                src_gap      <= src_idle_en ? pick_gap() : 0;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap  <= sink_gap - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 3) == 0)
                sink_gap <= pick_gap();
        end
    end

    // result check, then prediction of the beat accepted at this edge
    always @(posedge clk)
    begin
        avg_result_t exp_res;
        reading_t    acc_item;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: filt=%0d last=%0d",
                             $time, filtered_distance, last_distance);
            end
            else begin
                exp_res = expected_q.pop_front();
                if (filtered_distance !== exp_res.filt || last_distance !== exp_res.last ||
                    reading_valid !== exp_res.ok || restart_request !== exp_res.restart)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp filt=%0d last=%0d valid=%0b restart=%0b",
                                 $time, exp_res.filt, exp_res.last, exp_res.ok,
                                 exp_res.restart);
                        $display("%0t:          got filt=%0d last=%0d valid=%0b restart=%0b",
                                 $time, filtered_distance, last_distance, reading_valid,
                                 restart_request);
                    end
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            acc_item.act = action;
            acc_item.raw = raw_distance;
            acc_item.status = range_status;
            expected_q.push_back(filter_step(acc_item));
            acc_cnt <= acc_cnt + 1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("tb_range_sample_average_filter_unit: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: offset 0, limit 10
        queue_item(1'b0, 16'd0, 8'd0);
        queue_item(1'b0, 16'hFFFF, 8'd0);
        queue_item(1'b0, 16'd40000, 8'd1);
        queue_item(1'b1, 16'hFFFF, 8'hFF);
        queue_item(1'b0, 16'd300, 8'd0);
        settle();

        // clamp high, restart on first invalid
        set_mode(1023, 1);
        queue_item(1'b0, 16'hFFFF, 8'd0);
        queue_item(1'b0, 16'd64600, 8'd0);
        queue_item(1'b0, 16'd12, 8'h80);
        settle();

        // clamp low, restart after two invalids in a row
        set_mode(-1024, 2);
        queue_item(1'b0, 16'd0, 8'd0);
        queue_item(1'b0, 16'd1024, 8'd0);
        queue_item(1'b0, 16'd1025, 8'd0);
        queue_item(1'b0, 16'd5, 8'd1);
        queue_item(1'b0, 16'd700, 8'd0);
        queue_item(1'b0, 16'd5, 8'd2);
        queue_item(1'b0, 16'd5, 8'd4);
        settle();

        // zero limit: every invalid restarts
        set_mode(0, 0);
        queue_item(1'b0, 16'd9, 8'd1);
        queue_item(1'b0, 16'd77, 8'd0);
        queue_item(1'b0, 16'd9, 8'h55);
        settle();

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_mode($urandom_range(0, 2047) - 1024, $urandom_range(2, 6));
                1: set_mode(-1024, 1);
                2: set_mode(1023, 255);
                3: set_mode($urandom_range(0, 2047) - 1024, $urandom_range(1, 255));
                4: set_mode($urandom_range(0, 2047) - 1024, $urandom_range(3, 12));
                default: set_mode(0, 10);
            endcase
            src_idle_en  = (ph != 1 && ph != 4);
            sink_idle_en = (ph != 1);
            if (ph == 2)
            begin
                queue_random(40);
                // long invalid run up to the counter ceiling
                repeat (260) queue_item(1'b0, rand_raw(), 8'($urandom_range(1, 255)));
                queue_random(40);
            end
            else begin
                queue_random(90);
            end
            if (ph == 4)
                hold_req++;
            settle();
        end

        if (err_cnt == 0)
            $display("tb_range_sample_average_filter_unit: clean");
        else
            $display("tb_range_sample_average_filter_unit: errors");
        $finish;
    end

endmodule
